// ----- src/fdp_pkg.sv -----
// Shared types and constants for the first duplicate pair finder.
package fdp_pkg;

  localparam int SYM_W       = 8;
  localparam int NUM_SYMBOLS = 1 << SYM_W;
  localparam int IDX_W       = 10;
  localparam int MAX_LEN_DEF = 1024;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             present;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic             overflow;
  } result_t;

endpackage

// ----- src/fdp_ram.sv -----
// Generic simple dual-port RAM with registered read (old data on a same-address write).
module fdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/fdp_tracker.sv -----
// Per-array symbol flags, position counter and best-pair tracking.
module fdp_tracker #(
  parameter int MAX_LEN = fdp_pkg::MAX_LEN_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  go,
  input  fdp_pkg::item_t                        item,
  input  logic [$clog2(MAX_LEN):0]              first_ent,  // {repeated, first position}
  output logic                                  wr_en,
  output logic [fdp_pkg::SYM_W-1:0]             wr_addr,
  output logic [$clog2(MAX_LEN):0]              wr_data,    // {repeated, first position}
  output fdp_pkg::result_t                      result
);

  localparam int POS_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IW    = fdp_pkg::IDX_W;
  localparam int NS    = fdp_pkg::NUM_SYMBOLS;

  logic [NS-1:0]    seen_r, seen_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             best_valid_r, best_valid_nxt;
  logic [POS_W-1:0] best_first_r, best_first_nxt;
  logic [POS_W-1:0] best_second_r, best_second_nxt;
  logic             ovf_r, ovf_nxt;

  logic             byte_ok;
  logic [POS_W-1:0] pos;
  logic             seen_hit;
  logic             rep_hit;
  logic [POS_W-1:0] first_at;
  logic             better;

  assign byte_ok  = item.present && (cnt_r < CNT_W'(MAX_LEN));
  assign pos      = cnt_r[POS_W-1:0];
  assign seen_hit = seen_r[item.sym];
  // the table entry is only meaningful once the symbol was seen in this array
  assign rep_hit  = seen_hit && first_ent[POS_W];
  assign first_at = first_ent[POS_W-1:0];
  assign better   = byte_ok && seen_hit && !rep_hit &&
                    (!best_valid_r || (first_at < best_first_r));

  // write on the first occurrence (position) and the second (mark repeated)
  assign wr_en   = go && byte_ok && !rep_hit;
  assign wr_addr = item.sym;
  assign wr_data = seen_hit ? {1'b1, first_at} : {1'b0, pos};

  // Updated best pair, before the end-of-array clear.
  logic             upd_valid;
  logic [POS_W-1:0] upd_first;
  logic [POS_W-1:0] upd_second;
  logic             upd_ovf;

  always_comb begin
    upd_valid  = best_valid_r || better;
    upd_first  = better ? first_at : best_first_r;
    upd_second = better ? pos : best_second_r;
    upd_ovf    = ovf_r || (item.present && !byte_ok);

    result.found        = upd_valid;
    result.first_index  = upd_valid ? IW'(upd_first) : '0;
    result.second_index = upd_valid ? IW'(upd_second) : '0;
    result.overflow     = upd_ovf;
  end

  always_comb begin
    seen_nxt        = seen_r;
    cnt_nxt         = cnt_r;
    best_valid_nxt  = best_valid_r;
    best_first_nxt  = best_first_r;
    best_second_nxt = best_second_r;
    ovf_nxt         = ovf_r;
    if (go) begin
      if (item.last) begin
        seen_nxt        = '0;
        cnt_nxt         = '0;
        best_valid_nxt  = 1'b0;
        best_first_nxt  = '0;
        best_second_nxt = '0;
        ovf_nxt         = 1'b0;
      end else begin
        if (byte_ok) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (!seen_hit) begin
            seen_nxt[item.sym] = 1'b1;
          end
        end
        best_valid_nxt  = upd_valid;
        best_first_nxt  = upd_first;
        best_second_nxt = upd_second;
        ovf_nxt         = upd_ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r        <= '0;
      cnt_r         <= '0;
      best_valid_r  <= 1'b0;
      best_first_r  <= '0;
      best_second_r <= '0;
      ovf_r         <= 1'b0;
    end else begin
      seen_r        <= seen_nxt;
      cnt_r         <= cnt_nxt;
      best_valid_r  <= best_valid_nxt;
      best_first_r  <= best_first_nxt;
      best_second_r <= best_second_nxt;
      ovf_r         <= ovf_nxt;
    end
  end

endmodule

// ----- src/first_duplicate_pair_finder.sv -----
// First duplicate pair finder: a byte stream in, one pair report per array out.
//
// Input beats carry one byte each (in_tdata), a present flag (in_tuser) and
// an end-of-array mark (in_tlast). A beat with in_tuser low carries no byte;
// with in_tlast high it closes an empty or finished array. Bytes beyond
// MAX_LEN in one array are dropped and reported as overflow.
// One output beat follows each in_tlast beat: found, the first position i of
// the earliest repeated byte, the position j of its second occurrence, and
// the overflow flag. Positions appear in their low 10 bits.
// Throughput is one input beat per cycle while no report is blocked, set by
// the single read and write port of the first-position table; a write-to-read
// bypass keeps back-to-back bytes of the same value correct. After an in_tlast
// beat, out_tvalid follows the table read register, then the output register.
// The output register lets input run on while a report waits; a report
// stalled by out_tready low holds only a following in_tlast beat, and with
// it the input, since that beat then fills stage 1.
// Reset (synchronous, rst_n low) clears all per-array state; the block is
// ready the cycle after reset is released, with no clearing pass.
module first_duplicate_pair_finder #(
  parameter int MAX_LEN = fdp_pkg::MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_value
  input  logic        in_tuser,   // [0] present
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [0] found, [10:1] first_index, [20:11] second_index,
                                  // [21] overflow, [23:22] zero
);

  localparam int POS_W = $clog2(MAX_LEN);
  localparam int SW    = fdp_pkg::SYM_W;

  logic                 in_acc;
  logic                 s1_valid_r;
  fdp_pkg::item_t       s1_item_r;
  logic                 s1_go;
  logic                 byp_hit_r;
  logic [POS_W:0]       byp_data_r;
  logic [POS_W:0]       ram_rd;
  logic [POS_W:0]       first_ent;
  logic                 wr_en;
  logic [SW-1:0]        wr_addr;
  logic [POS_W:0]       wr_data;
  fdp_pkg::result_t     result;
  logic                 out_valid_r;
  fdp_pkg::result_t     out_res_r;

  // Advance stage 1 unless it holds an end beat and the report slot is blocked.
  assign s1_go     = s1_valid_r && (!s1_item_r.last || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  fdp_ram #(
    .WIDTH (POS_W + 1),
    .DEPTH (fdp_pkg::NUM_SYMBOLS)
  ) u_first_pos (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (in_tdata[SW-1:0]),
    .rd_data (ram_rd)
  );

  assign first_ent = byp_hit_r ? byp_data_r : ram_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_hit_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        // catch a table write landing on the address being read
        byp_hit_r  <= wr_en && (wr_addr == in_tdata[SW-1:0]);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.sym     <= in_tdata[SW-1:0];
      s1_item_r.present <= in_tuser;
      s1_item_r.last    <= in_tlast;
      byp_data_r        <= wr_data;
    end
  end

  fdp_tracker #(
    .MAX_LEN (MAX_LEN)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (s1_go),
    .item      (s1_item_r),
    .first_ent (first_ent),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_item_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item_r.last) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.overflow, out_res_r.second_index,
                       out_res_r.first_index, out_res_r.found};

  a_rise_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && s1_item_r.last))
    else $error("report raised without an end beat");

  a_write_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (s1_valid_r && s1_item_r.present && !s1_item_r.last) ||
              (s1_valid_r && s1_item_r.present))
    else $error("table write without a byte in stage 1");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.found) |->
      (out_res_r.first_index == '0) && (out_res_r.second_index == '0))
    else $error("positions nonzero in a not-found report");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_item_r.last && out_valid_r && !out_tready))
    else $error("input stalled without a blocked report");

endmodule
